FILE: hdl/ota_rx_pkg.sv
// ota_rx_pkg: codes and constants of the over-the-air update receiver
package ota_rx_pkg;

  // transfer phase codes
  localparam logic [1:0] PH_LISTEN   = 2'd0;
  localparam logic [1:0] PH_TRANSFER = 2'd1;
  localparam logic [1:0] PH_FINISHED = 2'd2;

  // acknowledgement codes
  typedef enum logic [2:0] {
    ACK_OK      = 3'd0,
    ACK_BUSY    = 3'd1,
    ACK_DENIED  = 3'd2,
    ACK_UNKNOWN = 3'd3,
    ACK_OOO     = 3'd4,
    ACK_ERR     = 3'd5
  } ack_code_e;

  // packet type bytes
  localparam logic [7:0] PKT_INIT   = 8'h00;
  localparam logic [7:0] PKT_DATA   = 8'h01;
  localparam logic [7:0] PKT_REBOOT = 8'h02;
  localparam logic [7:0] PKT_RESET  = 8'hf1;

  // header bytes counted in the length byte
  localparam logic [7:0] HDR_LEN = 8'd5;

  // event kinds on the func field
  localparam logic FUNC_RX      = 1'b0;
  localparam logic FUNC_TX_DONE = 1'b1;

endpackage

FILE: hdl/ota_update_receiver_top.sv
// ota_update_receiver_top: packet decode and transfer control of the update receiver
//
// Usage: each input item is either a received packet (func_i = 0) or the end of an
// acknowledgement transmission (func_i = 1). The block answers every item with one
// result item carrying the ack code, erase and flash write requests and the reboot
// request. The flash write outcome for a data packet arrives with the packet itself.
// Channels: in_valid_i / in_stall_o for items, out_valid_o / out_stall_i for results;
// an item moves at a rising edge where valid is high and stall is low.
// Path: an accepted item passes the input register, then decode and state update into
// the result register.
// Throughput: one item per cycle while the receiver does not stall, set by the single register stage of decode logic.
// Reset: phase returns to listening, counts clear, acks are armed, both stages empty.
// Stall: while the receiver stalls, the result register holds; one more item is
// taken into the input register and then in_stall_o rises until the result leaves.
module ota_update_receiver_top #(
  parameter int unsigned MAX_PAYLOAD = 56,
  localparam int unsigned LenW = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // input item channel
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            func_i,
  input  logic [7:0]      pkt_type_i,
  input  logic [15:0]     seq_or_count_i,
  input  logic [15:0]     flash_address_i,
  input  logic [7:0]      pkt_length_i,
  input  logic            write_ok_i,
  // result item channel
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            ack_valid_o,
  output logic [2:0]      ack_code_o,
  output logic            erase_req_o,
  output logic            write_req_o,
  output logic [15:0]     write_address_o,
  output logic [LenW-1:0] write_length_o,
  output logic            reboot_req_o
);

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  // input register
  logic        in_valid_q;
  logic        func_q;
  logic [7:0]  pkt_type_q;
  logic [15:0] seq_q;
  logic [15:0] addr_q;
  logic [7:0]  len_q;
  logic        wok_q;

  // transfer state
  logic [1:0]  phase_q, phase_d;
  logic [15:0] total_q, total_d;
  logic [15:0] rcvd_q, rcvd_d;
  logic        ack_ready_q, ack_ready_d;

  // result register
  logic            out_valid_q;
  logic            ack_valid_q, ack_valid_d;
  logic [2:0]      ack_code_q, ack_code_d;
  logic            erase_q, erase_d;
  logic            wreq_q, wreq_d;
  logic [15:0]     waddr_q, waddr_d;
  logic [LenW-1:0] wlen_q, wlen_d;
  logic            reboot_q, reboot_d;

  logic        advance;
  logic        process;
  logic [16:0] seq_next;
  logic        in_order;
  logic [7:0]  pay_len;
  logic [7:0]  pay_clamp;
  ota_rx_pkg::ack_code_e code;

  // pipeline flow
  assign advance    = !out_valid_q || !out_stall_i;
  assign process    = advance && in_valid_q;
  assign in_stall_o = in_valid_q && !advance;

  // input register load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      func_q     <= func_i;
      pkt_type_q <= pkt_type_i;
      seq_q      <= seq_or_count_i;
      addr_q     <= flash_address_i;
      len_q      <= pkt_length_i;
      wok_q      <= write_ok_i;
    end
  end

  // sequence check and payload length
  assign seq_next  = {1'b0, rcvd_q} + 17'd1;
  assign in_order  = ({1'b0, seq_q} == seq_next) && (seq_q <= total_q);
  assign pay_len   = (len_q >= ota_rx_pkg::HDR_LEN) ? (len_q - ota_rx_pkg::HDR_LEN) : 8'd0;
  assign pay_clamp = (pay_len > MaxLen) ? MaxLen : pay_len;

  // event decode and next state
  always_comb begin
    phase_d     = phase_q;
    total_d     = total_q;
    rcvd_d      = rcvd_q;
    ack_ready_d = ack_ready_q;
    code        = ota_rx_pkg::ACK_ERR;
    erase_d     = 1'b0;
    wreq_d      = 1'b0;
    waddr_d     = '0;
    wlen_d      = '0;
    reboot_d    = 1'b0;
    ack_valid_d = 1'b0;
    ack_code_d  = '0;
    if (func_q == ota_rx_pkg::FUNC_TX_DONE) begin
      reboot_d    = (phase_q == ota_rx_pkg::PH_FINISHED);
      ack_ready_d = 1'b1;
    end else begin
      case (pkt_type_q)
        ota_rx_pkg::PKT_INIT: begin
          if (phase_q == ota_rx_pkg::PH_LISTEN) begin
            total_d = seq_q;
            rcvd_d  = '0;
            erase_d = 1'b1;
            phase_d = ota_rx_pkg::PH_TRANSFER;
            code    = ota_rx_pkg::ACK_OK;
          end else begin
            code = ota_rx_pkg::ACK_BUSY;
          end
        end
        ota_rx_pkg::PKT_DATA: begin
          if (phase_q != ota_rx_pkg::PH_TRANSFER) begin
            code = ota_rx_pkg::ACK_DENIED;
          end else if (!in_order) begin
            code = ota_rx_pkg::ACK_OOO;
          end else begin
            wreq_d  = 1'b1;
            waddr_d = addr_q;
            wlen_d  = pay_clamp[LenW-1:0];
            if (wok_q) begin
              code   = ota_rx_pkg::ACK_OK;
              rcvd_d = seq_next[15:0];
            end
            // last packet finishes even when its write failed
            if (seq_q == total_q) begin
              code    = ota_rx_pkg::ACK_OK;
              phase_d = ota_rx_pkg::PH_FINISHED;
            end
          end
        end
        ota_rx_pkg::PKT_RESET: begin
          phase_d = ota_rx_pkg::PH_LISTEN;
          code    = ota_rx_pkg::ACK_OK;
        end
        ota_rx_pkg::PKT_REBOOT: begin
          phase_d = ota_rx_pkg::PH_FINISHED;
          code    = ota_rx_pkg::ACK_OK;
        end
        default: begin
          code = ota_rx_pkg::ACK_UNKNOWN;
        end
      endcase
      // one ack in flight at a time
      if (ack_ready_q) begin
        ack_valid_d = 1'b1;
        ack_code_d  = code;
        ack_ready_d = 1'b0;
      end
    end
  end

  // transfer state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ota_rx_pkg::PH_LISTEN;
      total_q     <= '0;
      rcvd_q      <= '0;
      ack_ready_q <= 1'b1;
    end else if (process) begin
      phase_q     <= phase_d;
      total_q     <= total_d;
      rcvd_q      <= rcvd_d;
      ack_ready_q <= ack_ready_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      ack_valid_q <= ack_valid_d;
      ack_code_q  <= ack_code_d;
      erase_q     <= erase_d;
      wreq_q      <= wreq_d;
      waddr_q     <= waddr_d;
      wlen_q      <= wlen_d;
      reboot_q    <= reboot_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ack_valid_o     = ack_valid_q;
  assign ack_code_o      = ack_code_q;
  assign erase_req_o     = erase_q;
  assign write_req_o     = wreq_q;
  assign write_address_o = waddr_q;
  assign write_length_o  = wlen_q;
  assign reboot_req_o    = reboot_q;

  // a sent ack disarms further acks until transmit done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && func_q == ota_rx_pkg::FUNC_RX && ack_ready_q) |=> !ack_ready_q)
    else $error("ack not disarmed after sending");

  // a reboot request only comes from a transmit-done item, which has no ack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reboot_req_o) |-> (!ack_valid_o && !erase_req_o && !write_req_o))
    else $error("reboot request mixed with packet result");

  // write fields are zero without a write request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !write_req_o) |-> (write_address_o == '0 && write_length_o == '0))
    else $error("write fields set without write request");

  // erase and write never in the same result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(erase_req_o && write_req_o))
    else $error("erase and write requested together");

endmodule
